>>> hw/rtl/dq_pkg.sv
// dq_pkg: mode codes, status codes and the control struct of the deque
// shared by dq_ptr and double_ended_queue_top; depends on nothing
package dq_pkg;

  typedef logic [2:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_CLEAR      = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // what one word does to the slot memory, and how it ends
  typedef struct packed {
    logic    wr;
    logic    rd;
    status_t status;
  } dq_ctrl_t;

endpackage

>>> hw/rtl/dq_ram.sv
// dq_ram: slot memory of the deque, one port, registered read data
// depends on nothing
module dq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wr_data,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> hw/rtl/dq_ptr.sv
// dq_ptr: front pointer and word count of the ring, slot address decode
// depends on dq_pkg
module dq_ptr #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  dq_pkg::mode_t    mode,
  output logic [AW-1:0]    addr,
  output dq_pkg::dq_ctrl_t ctrl,
  output logic [CW-1:0]    count_next
);
  import dq_pkg::*;

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW:0]   sum_w;
  logic [CW:0]   sum_m1;
  logic [AW-1:0] back_slot;
  logic [AW-1:0] last_slot;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic          full;
  logic          empty;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // front + count stays below twice the depth, so one subtract wraps it
  assign sum_w     = (CW+1)'(front) + (CW+1)'(count);
  assign sum_m1    = sum_w - (CW+1)'(1);
  assign back_slot = (sum_w >= (CW+1)'(DEPTH)) ? AW'(sum_w - (CW+1)'(DEPTH)) : AW'(sum_w);
  assign last_slot = (sum_m1 >= (CW+1)'(DEPTH)) ? AW'(sum_m1 - (CW+1)'(DEPTH)) : AW'(sum_m1);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);

  always_comb begin
    ctrl       = '{wr: 1'b0, rd: 1'b0, status: ST_OK};
    addr       = front;
    front_next = front;
    count_next = count;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          ctrl.status = ST_FULL;
        end else begin
          ctrl.wr    = 1'b1;
          addr       = front_dec;
          front_next = front_dec;
          count_next = count + CW'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          ctrl.status = ST_FULL;
        end else begin
          ctrl.wr    = 1'b1;
          addr       = back_slot;
          count_next = count + CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.rd    = 1'b1;
          addr       = front;
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.rd    = 1'b1;
          addr       = last_slot;
          count_next = count - CW'(1);
        end
      end
      MODE_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
        // unused codes leave everything as it is
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (take) begin
      front <= front_next;
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("deque count above depth");

  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.wr && ctrl.rd))
    else $error("slot read and write asked together");

  a_front_range: assert property (@(posedge clk) disable iff (rst)
    front <= AW'(DEPTH - 1))
    else $error("front pointer outside the ring");

endmodule

>>> hw/rtl/double_ended_queue_top.sv
// double_ended_queue_top: bounded deque of 32-bit words in a ring of slots
// depends on dq_pkg, dq_ptr and dq_ram
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+--------------------------------
//   in      | input     | in_valid / in_ready | mode, value
//   out     | output    | out_valid/out_ready | pop_value, status, count, is_empty
//
// push, clear, failed pops and unused codes go straight to the result register;
// a pop that removes a word first waits in S_READ for the registered read data.
// a word is taken whenever no pop is waiting on the memory and the result
// register is empty or being emptied in the same cycle.
// reset empties the deque; slot contents stay undefined.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dq_pkg::mode_t              mode,
  input  logic signed [31:0]         value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         pop_value,
  output dq_pkg::status_t            status,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       is_empty
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t        state;
  logic          take;
  logic [AW-1:0] addr;
  dq_ctrl_t      ctrl;
  logic [CW-1:0] count_next;
  logic [31:0]   rd_data;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;

  dq_ptr #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ptr (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (mode),
    .addr      (addr),
    .ctrl      (ctrl),
    .count_next(count_next)
  );

  dq_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (take && ctrl.wr),
    .rd_en  (take && ctrl.rd),
    .addr   (addr),
    .wr_data(value),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            pop_value <= '0;
            status    <= ctrl.status;
            count     <= count_next;
            is_empty  <= (count_next == '0);
            if (ctrl.rd) begin
              // result waits for the slot word
              state     <= S_READ;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          pop_value <= rd_data;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_read_no_result: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !out_valid && !in_ready)
    else $error("result or new word while a slot read is pending");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> out_valid && state == S_IDLE)
    else $error("popped word not delivered after the read");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_empty == (count == '0))
    else $error("empty flag disagrees with count");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    take && ctrl.rd |-> ctrl.status == ST_OK)
    else $error("slot read on a failed pop");

endmodule

>>> dv/deque_checker.sv
`timescale 1ns / 100ps
// deque_checker: watches both channels of double_ended_queue_top, keeps its own
// ring of slots to predict every result word and compares it field by field
// depends on dq_pkg
module deque_checker #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dq_pkg::mode_t      mode,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] pop_value,
  input  dq_pkg::status_t    status,
  input  logic [CW-1:0]      count,
  input  logic               is_empty,
  output int                 fail_count,
  output int                 pending
);
  import dq_pkg::*;

  typedef struct {
    logic signed [31:0] pop_value;
    status_t            status;
    logic [CW-1:0]      count;
    logic               is_empty;
  } deque_result_t;

  logic signed [31:0] ring [DEPTH];
  int unsigned        head_slot = 0;
  int unsigned        fill = 0;
  deque_result_t      awaited [$];
  int                 errors = 0;

  task automatic note_failure(input string msg);
    $display("%0t deque: %s", $time, msg);
    errors++;
  endtask

  // moves the ring model by one word and returns the result it must produce
  function automatic deque_result_t apply_word(input mode_t op, input logic signed [31:0] word);
    deque_result_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    case (op)
      MODE_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_slot       = (head_slot + DEPTH - 1) % DEPTH;
          ring[head_slot] = word;
          fill++;
        end
      end
      MODE_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[(head_slot + fill) % DEPTH] = word;
          fill++;
        end
      end
      MODE_POP_FRONT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = ring[head_slot];
          head_slot   = (head_slot + 1) % DEPTH;
          fill--;
        end
      end
      MODE_POP_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = ring[(head_slot + fill - 1) % DEPTH];
          fill--;
        end
      end
      MODE_CLEAR: begin
        head_slot = 0;
        fill      = 0;
      end
      default: ;
    endcase
    r.count    = CW'(fill);
    r.is_empty = (fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      head_slot = 0;
      fill      = 0;
      awaited.delete();
    end else begin
      // a result word cannot leave in the cycle its input is taken, so compare first
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          note_failure("result word with nothing awaited");
        end else begin
          want = awaited.pop_front();
          if (pop_value !== want.pop_value)
            note_failure($sformatf("pop_value %0d, expected %0d", pop_value, want.pop_value));
          if (status !== want.status)
            note_failure($sformatf("status %0d, expected %0d", status, want.status));
          if (count !== want.count)
            note_failure($sformatf("count %0d, expected %0d", count, want.count));
          if (is_empty !== want.is_empty)
            note_failure($sformatf("is_empty %b, expected %b", is_empty, want.is_empty));
        end
      end
      if (in_valid && in_ready)
        awaited.push_back(apply_word(mode, value));
    end
    pending    <= awaited.size();
    fail_count <= errors;
  end

endmodule

>>> dv/tb_double_ended_queue_top.sv
`timescale 1ns / 100ps
// tb_double_ended_queue_top: drives push, pop and clear words into the deque
// under varying idle and stall rates; checking is done by deque_checker
// depends on dq_pkg, double_ended_queue_top and deque_checker
module tb_double_ended_queue_top;
  import dq_pkg::*;

  localparam int    DEPTH             = 16;
  localparam int    CW                = $clog2(DEPTH + 1);
  localparam int    STALL_LIMIT       = 2000;
  localparam int    TAIL_CYCLES       = 8;
  localparam int    WORDS_PER_PHASE   = 230;
  localparam mode_t MODE_UNUSED_FIRST = 3'd5;
  localparam mode_t MODE_UNUSED_LAST  = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  mode_t              mode;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] pop_value;
  status_t            status;
  logic [CW-1:0]      count;
  logic               is_empty;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  double_ended_queue_top #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pop_value(pop_value),
    .status   (status),
    .count    (count),
    .is_empty (is_empty)
  );

  deque_checker #(.DEPTH(DEPTH)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_value (pop_value),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // valid stays high between back-to-back words and is only lowered for idle cycles
  task automatic send_word(input mode_t op, input logic signed [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    value    <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // bursts that fill, drain or mix, so both full and empty are hit often
  task automatic run_traffic(input int n_words);
    int    sent;
    int    burst;
    int    flavour;
    mode_t op;
    sent = 0;
    while (sent < n_words) begin
      flavour = $urandom_range(9);
      burst   = $urandom_range(24, 1);
      for (int k = 0; k < burst; k++) begin
        case (flavour)
          0, 1, 2: begin
            if ($urandom_range(9) == 0)
              op = MODE_POP_FRONT;
            else
              op = mode_t'($urandom_range(MODE_PUSH_BACK, MODE_PUSH_FRONT));
          end
          3, 4, 5: begin
            if ($urandom_range(9) == 0)
              op = MODE_PUSH_BACK;
            else
              op = mode_t'($urandom_range(MODE_POP_BACK, MODE_POP_FRONT));
          end
          9: op = mode_t'($urandom_range(MODE_UNUSED_LAST, MODE_PUSH_FRONT));
          default: begin
            if ($urandom_range(19) == 0)
              op = MODE_CLEAR;
            else
              op = mode_t'($urandom_range(MODE_POP_BACK, MODE_PUSH_FRONT));
          end
        endcase
        send_word(op, $urandom());
        if (op <= MODE_CLEAR)
          sent++;
      end
    end
  endtask

  initial begin
    logic signed [31:0] extreme_words [4];
    extreme_words[0] = 32'sh8000_0000;
    extreme_words[1] = 32'sh7fff_ffff;
    extreme_words[2] = '0;
    extreme_words[3] = -32'sd1;

    rst            <= 1'b1;
    in_valid       <= 1'b0;
    mode           <= MODE_PUSH_FRONT;
    value          <= '0;
    recv_stall_pct <= 71;
    send_idle_pct   = 12;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: pops on empty, fill to full from both ends, pushes on full
    send_word(MODE_POP_FRONT, extreme_words[3]);
    send_word(MODE_POP_BACK, extreme_words[1]);
    for (int k = 0; k < DEPTH; k++)
      send_word(k[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, (k < 4) ? extreme_words[k] : $urandom());
    send_word(MODE_PUSH_FRONT, extreme_words[1]);
    send_word(MODE_PUSH_BACK, extreme_words[0]);
    send_word(MODE_POP_FRONT, extreme_words[1]);
    send_word(MODE_POP_BACK, extreme_words[0]);
    send_word(MODE_UNUSED_FIRST, extreme_words[1]);
    send_word(MODE_UNUSED_FIRST + 3'd1, extreme_words[3]);
    send_word(MODE_UNUSED_LAST, extreme_words[0]);
    // clear with words still stored, then check the ring restarts cleanly
    send_word(MODE_CLEAR, extreme_words[3]);
    send_word(MODE_POP_BACK, '0);
    send_word(MODE_PUSH_FRONT, extreme_words[0]);
    send_word(MODE_POP_BACK, '0);

    run_traffic(WORDS_PER_PHASE);
    // hold the sender until every result word is out
    drain_results();

    send_idle_pct   = 71;
    recv_stall_pct <= 12;
    run_traffic(WORDS_PER_PHASE);

    send_idle_pct   = 0;
    recv_stall_pct <= 0;
    run_traffic(WORDS_PER_PHASE);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS double_ended_queue_top");
    else
      $display("FAIL double_ended_queue_top");
    $finish;
  end

  // ends the run if no word moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL double_ended_queue_top");
    $finish;
  end

endmodule
